[rtl/core/mbrh_pkg.sv]
package mbrh_pkg;

    localparam int NUM_REGS  = 8;
    localparam int FRAME_LEN = 12;
    localparam int REG_AW    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int RESP_MAX  = 9 + 2 * NUM_REGS;
    localparam int IDX_W     = $clog2(RESP_MAX);

    localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
    localparam logic [7:0] EXC_FLAG          = 8'h80;
    localparam logic [7:0] EXC_BAD_FUNCTION  = 8'h01;
    localparam logic [7:0] EXC_BAD_ADDRESS   = 8'h02;

    localparam logic CFG_UNIT_ID     = 1'b0;
    localparam logic CFG_REGS_IN_USE = 1'b1;

    localparam logic ACT_FRAME_BYTE = 1'b0;
    localparam logic ACT_LOAD       = 1'b1;

    localparam logic [IDX_W-1:0] POS_TID_HI   = IDX_W'(0);
    localparam logic [IDX_W-1:0] POS_TID_LO   = IDX_W'(1);
    localparam logic [IDX_W-1:0] POS_PROTO_HI = IDX_W'(2);
    localparam logic [IDX_W-1:0] POS_PROTO_LO = IDX_W'(3);
    localparam logic [IDX_W-1:0] POS_LEN_HI   = IDX_W'(4);
    localparam logic [IDX_W-1:0] POS_LEN_LO   = IDX_W'(5);
    localparam logic [IDX_W-1:0] POS_UNIT     = IDX_W'(6);
    localparam logic [IDX_W-1:0] POS_FUNC     = IDX_W'(7);
    localparam logic [IDX_W-1:0] POS_TAIL     = IDX_W'(8);
    localparam logic [IDX_W-1:0] POS_DATA     = IDX_W'(9);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SEND
    } seq_state_t;

    typedef struct packed {
        logic [15:0] tid;
        logic [7:0]  func;
        logic [15:0] start;
        logic [15:0] count;
    } frame_t;

endpackage

[rtl/core/mbrh_regfile.sv]
module mbrh_regfile (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       wr_en,
    input  logic [2:0]                 wr_idx,
    input  logic signed [31:0]         wr_value,
    input  logic [mbrh_pkg::REG_AW-1:0] rd_addr,
    output logic [15:0]                rd_data
);

    logic [15:0] regs_reg [mbrh_pkg::NUM_REGS];
    logic [15:0] sat_value;
    logic [mbrh_pkg::REG_AW-1:0] wr_addr;

    always_comb begin
        if (wr_value[31]) begin
            sat_value = 16'h0000;
        end else if (|wr_value[30:16]) begin
            sat_value = 16'hFFFF;
        end else begin
            sat_value = wr_value[15:0];
        end
    end

    assign wr_addr = mbrh_pkg::REG_AW'(wr_idx);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < mbrh_pkg::NUM_REGS; i++) begin
                regs_reg[i] <= 16'h0000;
            end
        end else if (wr_en && (int'(wr_idx) < mbrh_pkg::NUM_REGS)) begin
            regs_reg[wr_addr] <= sat_value;
        end
    end

    assign rd_data = (int'(rd_addr) < mbrh_pkg::NUM_REGS) ? regs_reg[rd_addr] : 16'h0000;

endmodule

[rtl/core/mbrh_frame.sv]
module mbrh_frame (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 byte_en,
    input  logic [7:0]           rx_byte,
    output logic                 frame_done,
    output mbrh_pkg::frame_t     frame
);

    logic [7:0] frame_bytes_reg [mbrh_pkg::FRAME_LEN-1];
    logic [7:0] final_byte_reg;
    logic [3:0] pos_reg;
    logic [3:0] pos_next;
    logic       at_end;

    assign at_end     = (pos_reg == 4'(mbrh_pkg::FRAME_LEN - 1));
    assign frame_done = byte_en && at_end;

    always_comb begin
        pos_next = pos_reg;
        if (byte_en) begin
            pos_next = at_end ? 4'd0 : pos_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= 4'd0;
        end else begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (byte_en) begin
            if (at_end) begin
                final_byte_reg <= rx_byte;
            end else begin
                frame_bytes_reg[pos_reg] <= rx_byte;
            end
        end
    end

    assign frame.tid   = {frame_bytes_reg[0], frame_bytes_reg[1]};
    assign frame.func  = frame_bytes_reg[7];
    assign frame.start = {frame_bytes_reg[8], frame_bytes_reg[9]};
    assign frame.count = {frame_bytes_reg[10], final_byte_reg};

endmodule

[rtl/core/mbrh_seq.sv]
module mbrh_seq (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        frame_done,
    input  mbrh_pkg::frame_t            frame,
    input  logic [7:0]                  unit_id,
    input  logic [3:0]                  regs_in_use,
    output logic                        in_ready,
    output logic [mbrh_pkg::REG_AW-1:0] rd_addr,
    input  logic [15:0]                 rd_data,
    output logic                        out_valid,
    output logic [7:0]                  out_byte,
    output logic                        out_last,
    input  logic                        out_ready
);

    localparam int IW = mbrh_pkg::IDX_W;
    localparam int AW = mbrh_pkg::REG_AW;

    mbrh_pkg::seq_state_t state_reg, state_next;

    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] last_idx_reg, last_idx_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic          exc_reg, exc_next;
    logic [7:0]    code_reg, code_next;
    logic [15:0]   len_reg, len_next;
    logic [7:0]    bcnt_reg, bcnt_next;
    logic          valid_reg, valid_next;
    logic [7:0]    data_reg, data_next;
    logic          last_reg, last_next;

    logic          decode_en;
    logic          send_active;
    logic          send_step;
    logic          is_last;
    logic [16:0]   add_a, add_b, add_sum;
    logic [16:0]   limit;
    logic          bad_func;
    logic          bad_addr;
    logic [7:0]    cur_byte;

    // shared adder: range sum while decoding, byte index while sending
    always_comb begin
        if (decode_en) begin
            add_a = {1'b0, frame.start};
            add_b = {1'b0, frame.count};
        end else begin
            add_a = 17'(idx_reg);
            add_b = 17'd1;
        end
    end
    assign add_sum = add_a + add_b;

    assign limit    = (17'(regs_in_use) > 17'(mbrh_pkg::NUM_REGS)) ?
                      17'(mbrh_pkg::NUM_REGS) : 17'(regs_in_use);
    assign bad_func = (frame.func != mbrh_pkg::FUNC_READ_HOLDING);
    assign bad_addr = (add_sum > limit);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mbrh_pkg::ST_IDLE: begin
                if (frame_done) begin
                    state_next = mbrh_pkg::ST_DECODE;
                end
            end
            mbrh_pkg::ST_DECODE: begin
                state_next = mbrh_pkg::ST_SEND;
            end
            mbrh_pkg::ST_SEND: begin
                if (send_step && is_last) begin
                    state_next = mbrh_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mbrh_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready    = 1'b0;
        decode_en   = 1'b0;
        send_active = 1'b0;
        unique case (state_reg)
            mbrh_pkg::ST_IDLE:   in_ready    = 1'b1;
            mbrh_pkg::ST_DECODE: decode_en   = 1'b1;
            mbrh_pkg::ST_SEND:   send_active = 1'b1;
            default:             in_ready    = 1'b0;
        endcase
    end

    assign send_step = send_active && (!valid_reg || out_ready);
    assign is_last   = (idx_reg == last_idx_reg);
    assign rd_addr   = addr_reg;

    always_comb begin
        unique case (idx_reg)
            mbrh_pkg::POS_TID_HI:   cur_byte = frame.tid[15:8];
            mbrh_pkg::POS_TID_LO:   cur_byte = frame.tid[7:0];
            mbrh_pkg::POS_PROTO_HI: cur_byte = 8'h00;
            mbrh_pkg::POS_PROTO_LO: cur_byte = 8'h00;
            mbrh_pkg::POS_LEN_HI:   cur_byte = len_reg[15:8];
            mbrh_pkg::POS_LEN_LO:   cur_byte = len_reg[7:0];
            mbrh_pkg::POS_UNIT:     cur_byte = unit_id;
            mbrh_pkg::POS_FUNC:     cur_byte = exc_reg ?
                                        (mbrh_pkg::FUNC_READ_HOLDING | mbrh_pkg::EXC_FLAG) :
                                        mbrh_pkg::FUNC_READ_HOLDING;
            mbrh_pkg::POS_TAIL:     cur_byte = exc_reg ? code_reg : bcnt_reg;
            default:                cur_byte = idx_reg[0] ? rd_data[15:8] : rd_data[7:0];
        endcase
    end

    always_comb begin
        idx_next      = idx_reg;
        last_idx_next = last_idx_reg;
        addr_next     = addr_reg;
        exc_next      = exc_reg;
        code_next     = code_reg;
        len_next      = len_reg;
        bcnt_next     = bcnt_reg;
        valid_next    = valid_reg && !out_ready;
        data_next     = data_reg;
        last_next     = last_reg;
        if (decode_en) begin
            idx_next  = mbrh_pkg::POS_TID_HI;
            addr_next = AW'(frame.start);
            exc_next  = bad_func || bad_addr;
            code_next = bad_func ? mbrh_pkg::EXC_BAD_FUNCTION : mbrh_pkg::EXC_BAD_ADDRESS;
            bcnt_next = {frame.count[6:0], 1'b0};
            if (bad_func || bad_addr) begin
                len_next      = 16'd3;
                last_idx_next = mbrh_pkg::POS_TAIL;
            end else begin
                len_next      = {frame.count[14:0], 1'b0} + 16'd3;
                last_idx_next = mbrh_pkg::POS_TAIL + IW'({frame.count[IW-2:0], 1'b0});
            end
        end
        if (send_step) begin
            valid_next = 1'b1;
            data_next  = cur_byte;
            last_next  = is_last;
            idx_next   = IW'(add_sum);
            // advance after the low byte of each register
            if ((idx_reg > mbrh_pkg::POS_DATA) && !idx_reg[0]) begin
                addr_next = addr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mbrh_pkg::ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        last_idx_reg <= last_idx_next;
        addr_reg     <= addr_next;
        exc_reg      <= exc_next;
        code_reg     <= code_next;
        len_reg      <= len_next;
        bcnt_reg     <= bcnt_next;
        data_reg     <= data_next;
        last_reg     <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_byte  = data_reg;
    assign out_last  = last_reg;

endmodule

[rtl/core/modbus_tcp_read_holding_responder.sv]
// After the twelfth request byte the sequencer decodes, then registers the first response
// byte. Throughput: one response byte per cycle while m_tready is high; a response of
// 9 to 9+2*NUM_REGS bytes keeps s_tready low from decode until its last byte is registered.
// Request bytes and register loads are accepted back to back while idle.
// Reset (aresetn low, synchronous): frame position and register file cleared,
// unit id 1, registers in use 8, output empty.
module modbus_tcp_read_holding_responder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // rx_byte[7:0], reg_index[10:8], reg_value[42:11]
    input  logic        s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // tx_byte[7:0]
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wdata
);

    logic        [7:0]  unit_id_reg;
    logic        [3:0]  regs_in_use_reg;
    logic               in_xfer;
    logic               byte_en;
    logic               load_en;
    logic               frame_done;
    mbrh_pkg::frame_t   frame;
    logic [mbrh_pkg::REG_AW-1:0] rd_addr;
    logic        [15:0] rd_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_id_reg     <= 8'd1;
            regs_in_use_reg <= 4'd8;
        end else if (cfg_we) begin
            unique case (cfg_index)
                mbrh_pkg::CFG_UNIT_ID:     unit_id_reg     <= cfg_wdata;
                mbrh_pkg::CFG_REGS_IN_USE: regs_in_use_reg <= cfg_wdata[3:0];
                default:                   unit_id_reg     <= unit_id_reg;
            endcase
        end
    end

    assign in_xfer = s_tvalid && s_tready;
    assign byte_en = in_xfer && (s_tuser == mbrh_pkg::ACT_FRAME_BYTE);
    assign load_en = in_xfer && (s_tuser == mbrh_pkg::ACT_LOAD);

    mbrh_regfile u_regfile (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (load_en),
        .wr_idx   (s_tdata[10:8]),
        .wr_value (s_tdata[42:11]),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    mbrh_frame u_frame (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_en    (byte_en),
        .rx_byte    (s_tdata[7:0]),
        .frame_done (frame_done),
        .frame      (frame)
    );

    mbrh_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .frame_done  (frame_done),
        .frame       (frame),
        .unit_id     (unit_id_reg),
        .regs_in_use (regs_in_use_reg),
        .in_ready    (s_tready),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .out_valid   (m_tvalid),
        .out_byte    (m_tdata),
        .out_last    (m_tlast),
        .out_ready   (m_tready)
    );

    a_done_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_done |=> !s_tready)
        else $error("sequencer stayed idle after a complete frame");

    a_idle_pending_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tready && m_tvalid) |-> m_tlast)
        else $error("idle with a pending byte that does not end a response");

    a_return_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(s_tready) |-> (m_tvalid && m_tlast))
        else $error("returned to idle before the final response byte");

endmodule
